[src/mtp_pkg.sv]
// Shared types and constants for the melody tone PWM player.
// Used by the player top level, its shared divider and the port checker.
`default_nettype none

package mtp_pkg;

    localparam int unsigned MAX_TONES_DEF   = 256;
    localparam int unsigned SOURCE_CLOCK_HZ = 125000000;

    localparam int unsigned DIV_W      = 32;
    localparam int unsigned CFG_ADDR_W = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 56;

    localparam logic [CFG_ADDR_W-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SONG_LEN = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_VOLUME   = 2'd2;

    localparam logic [15:0] DURATION_RST = 16'd100;
    localparam logic [8:0]  SONG_LEN_RST = 9'd1;
    localparam logic [6:0]  VOLUME_RST   = 7'd50;
    localparam logic [6:0]  VOLUME_MAX   = 7'd100;

    localparam logic [11:0] DIV16_MIN   = 12'd16;
    localparam logic [11:0] DIV16_MAX   = 12'd4095;
    localparam logic [31:0] LEVEL_DIV   = 32'd10000;

    // ceil(2^38 / 10000): exact floor division by 10000 for products below 2^25
    localparam logic [24:0] LEVEL_RECIP = 25'd27487791;
    localparam int unsigned LEVEL_SHIFT = 38;

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_START = 2'd2,
        MODE_STOP  = 2'd3
    } mtp_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POS,
        ST_TONE,
        ST_CEIL,
        ST_Q1,
        ST_WRAP,
        ST_MUL,
        ST_LVL,
        ST_FINISH
    } mtp_state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] num;
        logic [DIV_W-1:0] den;
    } mtp_div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
    } mtp_div_rsp_t;

endpackage

`default_nettype wire

[src/mtp_div.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on mtp_pkg for the request and response structs.
`default_nettype none

module mtp_div (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire mtp_pkg::mtp_div_req_t req,
    output mtp_pkg::mtp_div_rsp_t      rsp
);
    import mtp_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] den_reg;
    logic [DIV_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg, num_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // dividend shifts out at the top while quotient bits fill in at the bottom
    always_ff @(posedge aclk) begin
        if (req.start) begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? DIV_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIV_W-1:0];
            num_reg <= {num_reg[DIV_W-2:0], ge};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = num_reg;

endmodule

`default_nettype wire

[src/melody_tone_pwm_player_unit.sv]
// Melody tone PWM player: tone table memory, playback state and PWM settings.
// Depends on mtp_pkg and the shared divider mtp_div.
`default_nettype none

// Each beat on the s_ side is a command (tick, table write, start, stop) and
// gives exactly one result beat on the m_ side with the PWM settings for the
// tone now sounding. Commands are handled one at a time; the divisions run
// through one shared 32-bit divider at one quotient bit per cycle and the
// duty level comes from a reciprocal multiply, so the divider sets the time
// per command. A command that leaves the player stopped goes to the output
// load; others run the position division, past the song's end then the output
// load, for a pause also the table read, for a tone too low for the divider
// (a pause) the ceiling division too, and for a sounding tone four divisions,
// the table read, two multiply states, the output load and the return to
// idle. The result beat is valid when the next command can be taken. The tone
// table is a synchronous memory with no reset; entries must be written before
// a song reads them. No clearing pass is needed after reset.
module melody_tone_pwm_player_unit #(
    parameter int unsigned MAX_TONES = mtp_pkg::MAX_TONES_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // command channel
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [mtp_pkg::S_TDATA_W-1:0]       s_tdata,   // entry_index[7:0], tone_hz[23:8]
    input  wire  [1:0]                          s_tuser,   // mode[1:0]
    // result channel
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [mtp_pkg::M_TDATA_W-1:0]       m_tdata,   // pwm_on[0], div_whole[8:1],
                                                           // div_fraction[12:9],
                                                           // wrap_value[28:13],
                                                           // duty_level[44:29],
                                                           // is_playing[45], position[53:46]
    // configuration writes
    input  wire                                 cfg_wr_en,
    input  wire  [mtp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire  [mtp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mtp_pkg::*;

    localparam int unsigned AW    = $clog2(MAX_TONES);
    localparam int unsigned LEN_W = $clog2(MAX_TONES + 1);
    localparam logic [DIV_W-1:0] CLK_W   = DIV_W'(SOURCE_CLOCK_HZ);
    localparam logic [DIV_W-1:0] CLK16_W = {CLK_W[DIV_W-5:0], 4'b0000};

    // configuration
    logic [15:0] cfg_dur_reg;
    logic [8:0]  cfg_len_reg;
    logic [6:0]  cfg_vol_reg;

    // playback state and working values
    mtp_state_t  state_reg, state_next;
    logic [31:0] elapsed_reg, elapsed_next;
    logic        playing_reg, playing_next;
    logic [7:0]  pos_reg, pos_next;
    logic [15:0] f_reg, f_next;
    logic [11:0] div16_reg, div16_next;
    logic [15:0] wrap_reg, wrap_next;
    logic [24:0] prod_reg, prod_next;
    logic [15:0] lvl_reg, lvl_next;
    logic        res_on_reg, res_on_next;
    logic        res_play_reg, res_play_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // tone table
    logic [15:0]   tone_mem [MAX_TONES];
    logic [15:0]   rd_data_reg;
    logic          tbl_we;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    mtp_div_req_t div_req;
    mtp_div_rsp_t div_rsp;

    logic [7:0]       in_index;
    logic [15:0]      in_hz;
    logic [15:0]      dur_eff;
    logic [LEN_W-1:0] len_eff;
    logic [6:0]       vol_eff;
    logic [8:0]       vol3;
    logic [DIV_W-1:0] quot_m1;
    logic [DIV_W-1:0] f4096;
    logic [49:0]      lvl_prod;

    assign in_index = s_tdata[7:0];
    assign in_hz    = s_tdata[23:8];
    assign wr_addr  = AW'(in_index);
    assign rd_addr  = div_rsp.quot[AW-1:0];

    assign dur_eff = (cfg_dur_reg == 16'd0) ? 16'd1 : cfg_dur_reg;
    assign len_eff = (32'(cfg_len_reg) > 32'(MAX_TONES)) ? LEN_W'(MAX_TONES)
                                                         : LEN_W'(cfg_len_reg);
    assign vol_eff = (cfg_vol_reg > VOLUME_MAX) ? VOLUME_MAX : cfg_vol_reg;
    assign vol3    = 9'({vol_eff, 1'b0}) + 9'(vol_eff);
    assign quot_m1 = div_rsp.quot - 1'b1;
    assign f4096   = {4'b0000, rd_data_reg, 12'b0};
    assign lvl_prod = 50'(prod_reg) * 50'(LEVEL_RECIP);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    mtp_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_dur_reg <= DURATION_RST;
            cfg_len_reg <= SONG_LEN_RST;
            cfg_vol_reg <= VOLUME_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_DURATION: cfg_dur_reg <= cfg_wdata;
                CFG_SONG_LEN: cfg_len_reg <= cfg_wdata[8:0];
                CFG_VOLUME:   cfg_vol_reg <= cfg_wdata[6:0];
                default:      ;
            endcase
        end
    end

    // read is issued every cycle from the divider result; it is consumed in
    // ST_TONE, long after any table write from ST_IDLE
    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tone_mem[wr_addr] <= in_hz;
        end
        rd_data_reg <= tone_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            elapsed_reg  <= '0;
            playing_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elapsed_reg  <= elapsed_next;
            playing_reg  <= playing_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        f_reg        <= f_next;
        div16_reg    <= div16_next;
        wrap_reg     <= wrap_next;
        prod_reg     <= prod_next;
        lvl_reg      <= lvl_next;
        res_on_reg   <= res_on_next;
        res_play_reg <= res_play_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_comb begin
        logic [31:0] elapsed_cmd;
        logic        playing_cmd;

        state_next    = state_reg;
        elapsed_next  = elapsed_reg;
        playing_next  = playing_reg;
        pos_next      = pos_reg;
        f_next        = f_reg;
        div16_next    = div16_reg;
        wrap_next     = wrap_reg;
        prod_next     = prod_reg;
        lvl_next      = lvl_reg;
        res_on_next   = res_on_reg;
        res_play_next = res_play_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        tbl_we        = 1'b0;
        div_req       = '0;
        elapsed_cmd   = elapsed_reg;
        playing_cmd   = playing_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (mtp_mode_t'(s_tuser))
                        MODE_TICK: begin
                            if (playing_reg && (elapsed_reg != '1)) begin
                                elapsed_cmd = elapsed_reg + 32'd1;
                            end
                        end
                        MODE_WRITE: begin
                            tbl_we = (32'(in_index) < 32'(MAX_TONES));
                        end
                        MODE_START: begin
                            elapsed_cmd = '0;
                            playing_cmd = 1'b1;
                        end
                        MODE_STOP: begin
                            playing_cmd = 1'b0;
                        end
                    endcase
                    elapsed_next = elapsed_cmd;
                    playing_next = playing_cmd;
                    if (!playing_cmd) begin
                        res_on_next   = 1'b0;
                        res_play_next = 1'b0;
                        state_next    = ST_FINISH;
                    end else begin
                        div_req.start = 1'b1;
                        div_req.num   = elapsed_cmd;
                        div_req.den   = {16'b0, dur_eff};
                        state_next    = ST_POS;
                    end
                end
            end
            ST_POS: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot >= 32'(len_eff)) begin
                        playing_next  = 1'b0;
                        res_on_next   = 1'b0;
                        res_play_next = 1'b0;
                        state_next    = ST_FINISH;
                    end else begin
                        pos_next   = div_rsp.quot[7:0];
                        state_next = ST_TONE;
                    end
                end
            end
            ST_TONE: begin
                if (rd_data_reg == 16'd0) begin
                    res_on_next   = 1'b0;
                    res_play_next = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    // ceiling of clock / (f * 4096)
                    f_next        = rd_data_reg;
                    div_req.start = 1'b1;
                    div_req.num   = CLK_W + f4096 - 1'b1;
                    div_req.den   = f4096;
                    state_next    = ST_CEIL;
                end
            end
            ST_CEIL: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot > 32'(DIV16_MAX)) begin
                        // divider out of range: sounds as a pause
                        res_on_next   = 1'b0;
                        res_play_next = 1'b1;
                        state_next    = ST_FINISH;
                    end else begin
                        div16_next = (div_rsp.quot < 32'(DIV16_MIN)) ? DIV16_MIN
                                                                     : div_rsp.quot[11:0];
                        div_req.start = 1'b1;
                        div_req.num   = CLK16_W;
                        div_req.den   = (div_rsp.quot < 32'(DIV16_MIN)) ? 32'(DIV16_MIN)
                                                                        : div_rsp.quot;
                        state_next    = ST_Q1;
                    end
                end
            end
            ST_Q1: begin
                if (div_rsp.done) begin
                    div_req.start = 1'b1;
                    div_req.num   = div_rsp.quot;
                    div_req.den   = {16'b0, f_reg};
                    state_next    = ST_WRAP;
                end
            end
            ST_WRAP: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot == '0) begin
                        wrap_next = 16'd0;
                    end else if (|quot_m1[31:16]) begin
                        wrap_next = 16'hFFFF;
                    end else begin
                        wrap_next = quot_m1[15:0];
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = 25'(wrap_reg) * 25'(vol3);
                state_next = ST_LVL;
            end
            ST_LVL: begin
                // divide by 10000 through a scaled reciprocal
                lvl_next      = 16'(lvl_prod >> LEVEL_SHIFT);
                res_on_next   = 1'b1;
                res_play_next = 1'b1;
                state_next    = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00,
                                     res_play_reg ? pos_reg : 8'd0,
                                     res_play_reg,
                                     res_on_reg ? lvl_reg : 16'd0,
                                     res_on_reg ? wrap_reg : 16'd0,
                                     res_on_reg ? div16_reg[3:0] : 4'd0,
                                     res_on_reg ? div16_reg[11:4] : 8'd0,
                                     res_on_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/mtp_checker.sv]
// Port-level checks for the melody tone PWM player, bound to its top level.
// Depends on mtp_pkg for the channel widths.
`default_nettype none

module mtp_checker (
    input wire                            aclk,
    input wire                            aresetn,
    input wire                            s_tvalid,
    input wire                            s_tready,
    input wire                            m_tvalid,
    input wire                            m_tready,
    input wire [mtp_pkg::M_TDATA_W-1:0]   m_tdata
);
    import mtp_pkg::*;

    // a stalled result beat holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // one command at a time: busy in the cycle after a command beat
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("command taken while previous one in flight");

    // not playing: every other field is zero
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[45] |-> (m_tdata[44:0] == '0) && (m_tdata[53:46] == 8'd0))
        else $error("idle result carries non-zero fields");

    // sounding tone: playing, divider at least one, duty not above wrap
    a_tone_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |->
            m_tdata[45] && (m_tdata[8:1] != 8'd0) && (m_tdata[44:29] <= m_tdata[28:13]))
        else $error("sounding tone with inconsistent PWM settings");

endmodule

bind melody_tone_pwm_player_unit mtp_checker u_mtp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
